@@ rtl/core/mic_pkg.sv @@
// ============================================================================
// mic_pkg
// Shared types and constants for the multiset intersection counter.
// ============================================================================
`default_nettype none

package mic_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int COUNT_BITS    = 16;
    localparam int KEY_BITS      = 32;
    localparam int OP_BITS       = 2;

    // Entry index and fill count (fill count must reach TABLE_ENTRIES)
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Operation codes carried by an input transaction
    typedef enum logic [OP_BITS-1:0] {
        OP_LOAD  = 2'd0,
        OP_PROBE = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESP
    } state_t;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic signed [KEY_BITS-1:0]   key;
        logic        [COUNT_BITS-1:0] count;
    } entry_t;

    // One result transaction
    typedef struct packed {
        logic                       hit;
        logic signed [KEY_BITS-1:0] matched_key;
        logic                       table_full;
    } result_t;

    // RAM access request from the sequencer
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } ram_req_t;

endpackage

`default_nettype wire

@@ rtl/core/mic_ifs.sv @@
// ============================================================================
// mic_ifs
// Valid/ready channel interfaces for input items and results.
// ============================================================================
`default_nettype none

interface mic_item_if;
    logic                                 valid;
    logic                                 ready;
    logic [mic_pkg::OP_BITS-1:0]          operation;
    logic signed [mic_pkg::KEY_BITS-1:0]  key;

    modport source (output valid, output operation, output key, input ready);
    modport sink   (input valid, input operation, input key, output ready);
endinterface

interface mic_result_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 hit;
    logic signed [mic_pkg::KEY_BITS-1:0]  matched_key;
    logic                                 table_full;

    modport source (output valid, output hit, output matched_key, output table_full,
                    input ready);
    modport sink   (input valid, input hit, input matched_key, input table_full,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/mic_ram.sv @@
// ============================================================================
// mic_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module mic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mic_seq.sv @@
// ============================================================================
// mic_seq
// Sequencer: scans the filled part of the table one entry per cycle through
// a single key comparator, then on a match does one read-modify-write of the count.
// ============================================================================
`default_nettype none

module mic_seq (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [mic_pkg::OP_BITS-1:0]         operation,
    input  wire logic signed [mic_pkg::KEY_BITS-1:0] key,
    output logic                                     ready,
    output logic                                     res_valid,
    output mic_pkg::result_t                         res,
    input  wire logic                                res_take,
    output mic_pkg::ram_req_t                        ram_req,
    input  wire mic_pkg::entry_t                     ram_rd
);

    localparam int IDX_W  = mic_pkg::IDX_W;
    localparam int FILL_W = mic_pkg::FILL_W;
    localparam int CNT_W  = mic_pkg::COUNT_BITS;

    mic_pkg::state_t                      state_reg, state_next;
    logic [mic_pkg::OP_BITS-1:0]          op_reg, op_next;
    logic signed [mic_pkg::KEY_BITS-1:0]  key_reg, key_next;
    logic [FILL_W-1:0]                    fill_reg, fill_next;
    logic [FILL_W-1:0]                    addr_reg, addr_next;
    logic                                 pend_reg, pend_next;
    logic [IDX_W-1:0]                     pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]                     hit_idx_reg, hit_idx_next;
    logic [CNT_W-1:0]                     cnt_reg, cnt_next;
    mic_pkg::result_t                     res_reg, res_next;

    logic issue;
    logic key_match;
    logic has_room;

    // Filled entries always form a prefix, so the fill count bounds the scan
    assign issue     = (addr_reg != fill_reg);
    assign key_match = pend_reg && (ram_rd.key == key_reg);
    assign has_room  = (fill_reg != FILL_W'(mic_pkg::TABLE_ENTRIES));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mic_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if ((operation == mic_pkg::OP_LOAD) || (operation == mic_pkg::OP_PROBE))
                    begin
                        state_next = mic_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = mic_pkg::ST_RESP;
                    end
                end
            end
            mic_pkg::ST_SCAN:
            begin
                if (key_match)
                begin
                    state_next = mic_pkg::ST_UPDATE;
                end
                else if (!issue)
                begin
                    state_next = mic_pkg::ST_RESP;
                end
            end
            mic_pkg::ST_UPDATE:
            begin
                state_next = mic_pkg::ST_RESP;
            end
            mic_pkg::ST_RESP:
            begin
                if (res_take)
                begin
                    state_next = mic_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mic_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM requests
    always_comb
    begin
        op_next       = op_reg;
        key_next      = key_reg;
        fill_next     = fill_reg;
        addr_next     = addr_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        hit_idx_next  = hit_idx_reg;
        cnt_next      = cnt_reg;
        res_next      = res_reg;
        ram_req       = '0;

        unique case (state_reg)
            mic_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next   = operation;
                    key_next  = key;
                    addr_next = '0;
                    res_next  = '0;
                    if (operation == mic_pkg::OP_CLEAR)
                    begin
                        fill_next = '0;
                    end
                end
            end
            mic_pkg::ST_SCAN:
            begin
                // one read issued, previous read compared
                ram_req.rd_en   = issue;
                ram_req.rd_addr = addr_reg[IDX_W-1:0];
                pend_next       = issue;
                pend_idx_next   = addr_reg[IDX_W-1:0];
                if (issue)
                begin
                    addr_next = FILL_W'(addr_reg + 1'b1);
                end
                if (key_match)
                begin
                    hit_idx_next = pend_idx_reg;
                    cnt_next     = ram_rd.count;
                end
                else if (!issue)
                begin
                    // key absent: a load takes the next free entry
                    if (op_reg == mic_pkg::OP_LOAD)
                    begin
                        if (has_room)
                        begin
                            ram_req.wr_en         = 1'b1;
                            ram_req.wr_addr       = fill_reg[IDX_W-1:0];
                            ram_req.wr_data.key   = key_reg;
                            ram_req.wr_data.count = CNT_W'(1);
                            fill_next             = FILL_W'(fill_reg + 1'b1);
                        end
                        else
                        begin
                            res_next.table_full = 1'b1;
                        end
                    end
                end
            end
            mic_pkg::ST_UPDATE:
            begin
                ram_req.wr_addr     = hit_idx_reg;
                ram_req.wr_data.key = key_reg;
                if (op_reg == mic_pkg::OP_LOAD)
                begin
                    // saturating increment
                    ram_req.wr_en = 1'b1;
                    if (cnt_reg == mic_pkg::COUNT_MAX)
                    begin
                        ram_req.wr_data.count = cnt_reg;
                    end
                    else
                    begin
                        ram_req.wr_data.count = CNT_W'(cnt_reg + 1'b1);
                    end
                end
                else if (cnt_reg != '0)
                begin
                    ram_req.wr_en         = 1'b1;
                    ram_req.wr_data.count = CNT_W'(cnt_reg - 1'b1);
                    res_next.hit          = 1'b1;
                    res_next.matched_key  = key_reg;
                end
            end
            mic_pkg::ST_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign ready     = (state_reg == mic_pkg::ST_IDLE);
    assign res_valid = (state_reg == mic_pkg::ST_RESP);
    assign res       = res_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mic_pkg::ST_IDLE;
            fill_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        addr_reg     <= addr_next;
        pend_idx_reg <= pend_idx_next;
        hit_idx_reg  <= hit_idx_next;
        cnt_reg      <= cnt_next;
        res_reg      <= res_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/multiset_intersection_counter.sv @@
// ============================================================================
// multiset_intersection_counter
// Key table with occurrence counts for streaming multiset intersection.
// ============================================================================
//
//  Channel  Role    Payload                           Transaction
//  -------  ------  --------------------------------  ---------------------
//  item     sink    operation[1:0], key[31:0] signed  valid & ready high
//  result   source  hit, matched_key[31:0], full      valid & ready high
//
//  Load and probe scan the table RAM one filled entry per cycle through one
//  key comparator, followed on a match by one count read-modify-write; a
//  load of an absent key writes it to the next free entry if there is room.
//  Clear and unused codes go straight to the result without a scan.
//  item.ready is high only while the sequencer is idle; one result is held
//  in an output register, so a stalled result delays only the next item.
//  Reset clears the fill count; no clearing pass is needed.
//
`default_nettype none

module multiset_intersection_counter (
    input wire logic     clk,
    input wire logic     rst_n,
    mic_item_if.sink     item,
    mic_result_if.source result
);

    mic_pkg::ram_req_t ram_req;
    mic_pkg::entry_t   ram_rd;
    mic_pkg::result_t  seq_res;
    logic              seq_ready;
    logic              seq_res_valid;
    logic              res_take;
    logic              start;

    logic              out_valid_reg;
    mic_pkg::result_t  out_res_reg;

    assign start      = item.valid && seq_ready;
    assign item.ready = seq_ready;

    // Sequencer and compare unit
    mic_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .key       (item.key),
        .ready     (seq_ready),
        .res_valid (seq_res_valid),
        .res       (seq_res),
        .res_take  (res_take),
        .ram_req   (ram_req),
        .ram_rd    (ram_rd)
    );

    // Table storage: key and count per entry
    mic_ram #(
        .WIDTH ($bits(mic_pkg::entry_t)),
        .DEPTH (mic_pkg::TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd)
    );

    // Output register: loads when empty or being drained
    assign res_take = seq_res_valid && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= seq_res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.hit         = out_res_reg.hit;
    assign result.matched_key = out_res_reg.matched_key;
    assign result.table_full  = out_res_reg.table_full;

endmodule

`default_nettype wire

@@ rtl/core/mic_checker.sv @@
// ============================================================================
// mic_checker
// Port-level checks of the multiset intersection counter over time.
// ============================================================================
`default_nettype none

module mic_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                item_valid,
    input wire logic                                item_ready,
    input wire logic                                result_valid,
    input wire logic                                result_ready,
    input wire logic                                result_hit,
    input wire logic signed [mic_pkg::KEY_BITS-1:0] result_matched_key,
    input wire logic                                result_table_full
);

    // Result held until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped while stalled");

    // Stalled result payload stays put
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(result_hit) && $stable(result_matched_key) && $stable(result_table_full))
        else $error("result payload changed while stalled");

    // A probe hit and a dropped load never share a transaction
    a_hit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result_hit && result_table_full))
        else $error("hit and table_full both set");

    // Matched key is zero on a miss
    a_miss_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_hit |-> (result_matched_key == '0))
        else $error("matched_key nonzero without hit");

    // Block is busy in the cycle after it takes an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("ready high right after an accepted item");

endmodule

bind multiset_intersection_counter mic_checker u_mic_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item.valid),
    .item_ready         (item.ready),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_hit         (result.hit),
    .result_matched_key (result.matched_key),
    .result_table_full  (result.table_full)
);

`default_nettype wire
